[src/smau_pkg.sv]
// Shared types and constants for the stack machine arithmetic unit.
package smau_pkg;

    // Word and field widths
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;
    localparam int DEPTH_W  = 7;
    localparam int MIN_OPS  = 2;

    // Instruction codes
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OP_W-1:0] OP_MOD  = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SHORT   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DIVZERO = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

    // Per-cell shift control
    typedef struct packed {
        logic take_up;      // load from the neighbor nearer the top
        logic take_down;    // load from the neighbor nearer the bottom
    } cell_ctrl_t;

endpackage

[src/stack_machine_arith_unit.sv]
// Stack machine ALU top level: control, operand stack cell chain and divider.
//
// Executes one instruction per input transaction (push, add, sub, mul, div,
// mod) on a stack of STACK_DEPTH signed 32-bit words and returns one result
// transaction with status, new top of stack and new depth. The stack is a
// chain of cells with the top in cell 0; push shifts every entry one cell
// down, an arithmetic instruction writes the result into cell 0 and shifts
// the rest up. Push, add, sub, errors and unknown codes write the result
// register directly; mul registers a 32x32 multiply, then writes back;
// div and mod start the iterative divider (one quotient bit per cycle), then
// write back. A new transaction is taken once the previous one has finished
// and the result register is free or being read. Stack entries power up
// undefined and are only read below the current depth.
module stack_machine_arith_unit
    import smau_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_req_type,
    input  logic signed [DATA_W-1:0]  s_push_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [STAT_W-1:0]         m_status,
    output logic signed [DATA_W-1:0]  m_top_value,
    output logic [DEPTH_W-1:0]        m_depth
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int EXT_W = CNT_W + DEPTH_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]   m_status_reg, m_status_next;
    logic [DATA_W-1:0]   m_top_reg, m_top_next;
    logic [DEPTH_W-1:0]  m_depth_reg, m_depth_next;
    logic [DATA_W-1:0]   prod_reg, prod_next;
    logic                is_mod_reg, is_mod_next;

    logic                s_fire;
    logic                push_en;
    logic                pop_en;
    logic [DATA_W-1:0]   new_top;
    logic [DATA_W-1:0]   cur_top;
    logic [DATA_W-1:0]   cell_q [STACK_DEPTH];
    logic                div_start;
    logic                div_done;
    logic [DATA_W-1:0]   div_quo;
    logic [DATA_W-1:0]   div_rem;

    // Low 7 bits of an entry count
    function automatic logic [DEPTH_W-1:0] depth7(input logic [CNT_W-1:0] c);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(c);
        return ext[DEPTH_W-1:0];
    endfunction

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;
    assign cur_top = (count_reg != '0) ? cell_q[0] : '0;

    // Instruction decode and sequencing
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_top_next    = m_top_reg;
        m_depth_next  = m_depth_reg;
        prod_next     = prod_reg;
        is_mod_next   = is_mod_reg;
        push_en       = 1'b0;
        pop_en        = 1'b0;
        new_top       = s_push_value;
        div_start     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_top_next    = cur_top;
                    m_depth_next  = depth7(count_reg);
                    if (s_req_type == OP_PUSH) begin
                        if (count_reg == CNT_W'(STACK_DEPTH)) begin
                            m_status_next = STAT_FULL;
                        end else begin
                            push_en      = 1'b1;
                            count_next   = count_reg + 1'b1;
                            m_top_next   = s_push_value;
                            m_depth_next = depth7(count_reg + 1'b1);
                        end
                    end else if (s_req_type inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                                                    OP_MOD}) begin
                        if (count_reg < CNT_W'(MIN_OPS)) begin
                            m_status_next = STAT_SHORT;
                        end else if ((s_req_type == OP_DIV || s_req_type == OP_MOD)
                                     && cell_q[0] == '0) begin
                            m_status_next = STAT_DIVZERO;
                        end else if (s_req_type == OP_ADD) begin
                            pop_en  = 1'b1;
                            new_top = cell_q[1] + cell_q[0];
                        end else if (s_req_type == OP_SUB) begin
                            pop_en  = 1'b1;
                            new_top = cell_q[1] - cell_q[0];
                        end else if (s_req_type == OP_MUL) begin
                            m_valid_next = 1'b0;
                            prod_next    = cell_q[1] * cell_q[0];
                            state_next   = ST_MUL;
                        end else begin
                            m_valid_next = 1'b0;
                            div_start    = 1'b1;
                            is_mod_next  = (s_req_type == OP_MOD);
                            state_next   = ST_DIV;
                        end
                    end
                end
            end
            ST_MUL: begin
                pop_en     = 1'b1;
                new_top    = prod_reg;
                state_next = ST_IDLE;
            end
            ST_DIV: begin
                if (div_done) begin
                    pop_en     = 1'b1;
                    new_top    = is_mod_reg ? div_rem : div_quo;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Write back of an arithmetic result: one entry popped
        if (pop_en) begin
            count_next    = count_reg - 1'b1;
            m_valid_next  = 1'b1;
            m_status_next = STAT_OK;
            m_top_next    = new_top;
            m_depth_next  = depth7(count_reg - 1'b1);
        end
    end

    // State and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_status_reg <= m_status_next;
        m_top_reg    <= m_top_next;
        m_depth_reg  <= m_depth_next;
        prod_reg     <= prod_next;
        is_mod_reg   <= is_mod_next;
    end

    // Operand stack: cell 0 is the top
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        cell_ctrl_t        ctrl;
        logic [DATA_W-1:0] up_data;
        logic [DATA_W-1:0] down_data;

        if (i == 0) begin : g_top
            assign ctrl.take_up   = push_en || pop_en;
            assign ctrl.take_down = 1'b0;
            assign up_data        = new_top;
        end else begin : g_inner
            assign ctrl.take_up   = push_en;
            assign ctrl.take_down = pop_en;
            assign up_data        = cell_q[i-1];
        end

        if (i == STACK_DEPTH - 1) begin : g_last
            assign down_data = '0;
        end else begin : g_mid
            assign down_data = cell_q[i+1];
        end

        smau_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .up_data   (up_data),
            .down_data (down_data),
            .data      (cell_q[i])
        );
    end

    // Divide unit: second entry over top entry
    smau_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (cell_q[1]),
        .divisor   (cell_q[0]),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_top_value = m_top_reg;
    assign m_depth     = m_depth_reg;

endmodule

[src/smau_cell.sv]
// One stack entry: holds a word and shifts it to or from its neighbors.
module smau_cell
    import smau_pkg::*;
(
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] up_data,
    input  logic [DATA_W-1:0] down_data,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;

    // Push moves entries down, pop moves them up
    always_ff @(posedge aclk) begin
        if (ctrl.take_up) begin
            data_reg <= up_data;
        end else if (ctrl.take_down) begin
            data_reg <= down_data;
        end
    end

    assign data = data_reg;

endmodule

[src/smau_divider.sv]
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
module smau_divider
    import smau_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient,
    output logic [DATA_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] div_reg, div_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    // Restoring step
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        if (start) begin
            // Work on magnitudes; signs are applied at the output
            busy_next  = 1'b1;
            cnt_next   = '0;
            rem_next   = '0;
            quo_next   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            div_next   = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_q_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            neg_r_next = dividend[DATA_W-1];
        end else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    // Sign fix: quotient by sign product, remainder follows the dividend
    assign done      = done_reg;
    assign quotient  = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;

endmodule
